// ===== rtl/btlcs_pkg.sv =====
// ----------------------------------------------------------------------------
// btlcs_pkg
// Shared types and constants of the b-tree leaf chunk splitter.
// ----------------------------------------------------------------------------
package btlcs_pkg;

   localparam int INDEX_BITS = 24;
   localparam int CFG_BITS   = 7;
   localparam int FULL_BITS  = 2 * CFG_BITS;
   localparam int NODE_BITS  = 7;
   localparam int ADDR_BITS  = 3;
   localparam int DATA_BITS  = 32;

   localparam logic [CFG_BITS-1:0] MIN_CHILDREN  = CFG_BITS'(5);
   localparam logic [CFG_BITS-1:0] RESET_KPL     = CFG_BITS'(16);
   localparam logic [CFG_BITS-1:0] RESET_CPN     = CFG_BITS'(16);
   localparam logic [NODE_BITS-1:0] TWO_NODES    = NODE_BITS'(2);

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_TOO_MANY = 2'd2;

   localparam logic REG_KPL = 1'b0;
   localparam logic REG_CPN = 1'b1;

   typedef struct packed {
      logic [INDEX_BITS-1:0] begin_index;
      logic [INDEX_BITS-1:0] end_index;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] chunk_start;
      logic [INDEX_BITS-1:0] chunk_count;
      logic                  last_chunk;
      logic [1:0]            status;
   } rsp_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] begin_index;
      logic [INDEX_BITS-1:0] end_index;
      logic [INDEX_BITS-1:0] leaves;
      logic [NODE_BITS-1:0]  nodes;
      logic [CFG_BITS-1:0]   kpl;
      logic [CFG_BITS-1:0]   cpn;
      logic [FULL_BITS-1:0]  full;
      logic [1:0]            status;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== rtl/btlcs_front.sv =====
// ----------------------------------------------------------------------------
// btlcs_front
// Takes a range, counts leaves and nodes with a shared restoring divider
// and hands the classified job to the queue.
// ----------------------------------------------------------------------------
module btlcs_front import btlcs_pkg::*; #(
   parameter int MAX_CHUNKS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_payload,
   input  logic [CFG_BITS-1:0] kpl_cfg,
   input  logic [CFG_BITS-1:0] cpn_cfg,
   input  q_status_type        q_status,
   output logic                push,
   output job_type             job
);

   localparam int DIV_BITS  = INDEX_BITS + 1;
   localparam int STEP_BITS = $clog2(DIV_BITS);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIV_BITS - 1);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type         state_ff, state_in;
   job_type                 job_ff, job_in;
   logic [DIV_BITS-1:0]     num_ff, num_in;
   logic [CFG_BITS-1:0]     rem_ff, rem_in;
   logic [CFG_BITS-1:0]     div_ff, div_in;
   logic [STEP_BITS-1:0]    cnt_ff, cnt_in;
   logic                    phase_ff, phase_in;

   logic [CFG_BITS-1:0]     kpl;
   logic [CFG_BITS-1:0]     cpn;
   logic [INDEX_BITS-1:0]   diff;
   logic [CFG_BITS:0]       trial;
   logic [CFG_BITS:0]       trial_sub;
   logic                    ge;
   logic [DIV_BITS-1:0]     quo;

   always_comb begin
      kpl       = (kpl_cfg == '0) ? CFG_BITS'(1) : kpl_cfg;
      cpn       = (cpn_cfg < MIN_CHILDREN) ? MIN_CHILDREN : cpn_cfg;
      diff      = req_payload.end_index - req_payload.begin_index;
      trial     = {rem_ff, num_ff[DIV_BITS-1]};
      trial_sub = trial - {1'b0, div_ff};
      ge        = (trial >= {1'b0, div_ff});
      quo       = {num_ff[DIV_BITS-2:0], ge};

      state_in = state_ff;
      job_in   = job_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      push     = 1'b0;

      case (state_ff)
         F_IDLE: begin
            if (start) begin
               job_in.begin_index = req_payload.begin_index;
               job_in.end_index   = req_payload.end_index;
               job_in.leaves      = '0;
               job_in.nodes       = '0;
               job_in.kpl         = kpl;
               job_in.cpn         = cpn;
               job_in.full        = FULL_BITS'(kpl) * FULL_BITS'(cpn);
               job_in.status      = ST_OK;
               if (req_payload.end_index <= req_payload.begin_index) begin
                  job_in.status = ST_EMPTY;
                  state_in      = F_PUSH;
               end else begin
                  num_in   = DIV_BITS'(diff) + DIV_BITS'(kpl) - DIV_BITS'(1);
                  div_in   = kpl;
                  rem_in   = '0;
                  cnt_in   = '0;
                  phase_in = 1'b0;
                  state_in = F_DIV;
               end
            end
         end
         F_DIV: begin
            num_in = quo;
            rem_in = ge ? trial_sub[CFG_BITS-1:0] : trial[CFG_BITS-1:0];
            cnt_in = cnt_ff + STEP_BITS'(1);
            if (cnt_ff == LAST_STEP) begin
               if (!phase_ff) begin
                  job_in.leaves = quo[INDEX_BITS-1:0];
                  num_in   = DIV_BITS'(quo[INDEX_BITS-1:0]) + DIV_BITS'(job_ff.cpn)
                             - DIV_BITS'(1);
                  div_in   = job_ff.cpn;
                  rem_in   = '0;
                  cnt_in   = '0;
                  phase_in = 1'b1;
               end else begin
                  job_in.nodes = quo[NODE_BITS-1:0];
                  if (quo > DIV_BITS'(MAX_CHUNKS)) begin
                     job_in.status = ST_TOO_MANY;
                  end
                  state_in = F_PUSH;
               end
            end
         end
         F_PUSH: begin
            if (!q_status.full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff   <= job_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      cnt_ff   <= cnt_in;
      phase_ff <= phase_in;
   end

   assign busy = (state_ff != F_IDLE);
   assign job  = job_ff;

endmodule

// ===== rtl/btlcs_queue.sv =====
// ----------------------------------------------------------------------------
// btlcs_queue
// Short job queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
module btlcs_queue import btlcs_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_job,
   input  logic         pop,
   output job_type      head_job,
   output q_status_type q_status
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

   job_type               entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job       = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign q_status.empty = (count_ff == '0);

endmodule

// ===== rtl/btlcs_back.sv =====
// ----------------------------------------------------------------------------
// btlcs_back
// Walks one job node by node and drives one chunk result per cycle.
// ----------------------------------------------------------------------------
module btlcs_back import btlcs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  job_type      head_job,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   output rsp_type      rsp_payload
);

   localparam int PROD_BITS = INDEX_BITS + CFG_BITS;

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_RUN  = 2'b10
   } back_state_type;

   back_state_type          state_ff, state_in;
   job_type                 cur_ff, cur_in;
   logic [INDEX_BITS-1:0]   pos_ff, pos_in;
   logic [INDEX_BITS-1:0]   leaves_ff, leaves_in;
   logic [NODE_BITS-1:0]    nodes_ff, nodes_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [INDEX_BITS:0]     leaves_up;
   logic [INDEX_BITS-1:0]   half;
   logic [PROD_BITS-1:0]    prod;
   logic [INDEX_BITS-1:0]   cnt;
   logic [INDEX_BITS-1:0]   full;

   always_comb begin
      leaves_up = {1'b0, leaves_ff} + (INDEX_BITS+1)'(1);
      half      = leaves_up[INDEX_BITS:1];
      prod      = PROD_BITS'(half) * PROD_BITS'(cur_ff.kpl);
      cnt       = prod[INDEX_BITS-1:0];
      full      = INDEX_BITS'(cur_ff.full);

      state_in     = state_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      leaves_in    = leaves_ff;
      nodes_in     = nodes_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;

      case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               pop       = 1'b1;
               cur_in    = head_job;
               pos_in    = head_job.begin_index;
               leaves_in = head_job.leaves;
               nodes_in  = head_job.nodes;
               state_in  = B_RUN;
            end
         end
         B_RUN: begin
            rsp_valid_in = 1'b1;
            if (cur_ff.status != ST_OK) begin
               rsp_in.chunk_start = cur_ff.begin_index;
               rsp_in.chunk_count = '0;
               rsp_in.last_chunk  = 1'b1;
               rsp_in.status      = cur_ff.status;
               state_in           = B_IDLE;
            end else if (nodes_ff > TWO_NODES) begin
               rsp_in.chunk_start = pos_ff;
               rsp_in.chunk_count = full;
               rsp_in.last_chunk  = 1'b0;
               rsp_in.status      = ST_OK;
               pos_in    = pos_ff + full;
               leaves_in = leaves_ff - INDEX_BITS'(cur_ff.cpn);
               nodes_in  = nodes_ff - NODE_BITS'(1);
            end else if (nodes_ff == TWO_NODES) begin
               rsp_in.chunk_start = pos_ff;
               rsp_in.chunk_count = cnt;
               rsp_in.last_chunk  = 1'b0;
               rsp_in.status      = ST_OK;
               pos_in    = pos_ff + cnt;
               leaves_in = leaves_ff - half;
               nodes_in  = nodes_ff - NODE_BITS'(1);
            end else begin
               rsp_in.chunk_start = pos_ff;
               rsp_in.chunk_count = cur_ff.end_index - pos_ff;
               rsp_in.last_chunk  = 1'b1;
               rsp_in.status      = ST_OK;
               state_in           = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff    <= cur_in;
      pos_ff    <= pos_in;
      leaves_ff <= leaves_in;
      nodes_ff  <= nodes_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/btree_leaf_chunk_splitter.sv =====
// ----------------------------------------------------------------------------
// btree_leaf_chunk_splitter
// Splits a key index range into one chunk per b-tree node.
// ----------------------------------------------------------------------------
// A range is taken when start is high and busy is low. An empty range goes
// straight to the queue without using the divider. Any other range first
// runs through the front's restoring divider, one quotient bit per cycle
// (leaves, then nodes), and then queues the job; busy stays high until the
// job is queued, longer while the queue is full. A two-entry queue feeds
// the back end, which emits one chunk result per cycle after loading a job
// from the queue. While the back end emits, the front already works on the
// next range, so the two overlap. Results are strobed on rsp_valid for one
// cycle each and cannot be held off.
// ----------------------------------------------------------------------------
module btree_leaf_chunk_splitter import btlcs_pkg::*; #(
   parameter int MAX_CHUNKS = 64,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   output rsp_type              rsp_payload,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   logic [CFG_BITS-1:0] kpl_ff, kpl_in;
   logic [CFG_BITS-1:0] cpn_ff, cpn_in;
   logic                cfg_write;

   logic                push;
   logic                pop;
   job_type             push_job;
   job_type             head_job;
   q_status_type        q_status;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      kpl_in = kpl_ff;
      cpn_in = cpn_ff;
      if (cfg_write) begin
         case (paddr[2])
            REG_KPL: kpl_in = pwdata[CFG_BITS-1:0];
            REG_CPN: cpn_in = pwdata[CFG_BITS-1:0];
            default: begin
               kpl_in = kpl_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_KPL: prdata = DATA_BITS'(kpl_ff);
         REG_CPN: prdata = DATA_BITS'(cpn_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kpl_ff <= RESET_KPL;
         cpn_ff <= RESET_CPN;
      end else begin
         kpl_ff <= kpl_in;
         cpn_ff <= cpn_in;
      end
   end

   btlcs_front #(
      .MAX_CHUNKS (MAX_CHUNKS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .kpl_cfg     (kpl_ff),
      .cpn_cfg     (cpn_ff),
      .q_status    (q_status),
      .push        (push),
      .job         (push_job)
   );

   btlcs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   btlcs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // an accepted range makes the front busy in the following cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("front not busy after accept");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty))
      else $error("pop from empty queue");

   // error results are single, final and empty
   a_error_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |->
         rsp_payload.last_chunk && rsp_payload.chunk_count == '0)
      else $error("malformed error result");

endmodule

// ===== test/btree_leaf_chunk_splitter_checker.sv =====
// ----------------------------------------------------------------------------
// btree_leaf_chunk_splitter_checker
// Watches the request, result and register ports of the chunk splitter. It
// tracks the two split registers from the writes it sees and checks every
// register read. For each accepted range it queues the chunks that the range
// must produce, then compares each strobed result, field by field, against
// the oldest queued chunk. It hands a failure count and the number of chunks
// still outstanding to the testbench top.
// ----------------------------------------------------------------------------
module btree_leaf_chunk_splitter_checker import btlcs_pkg::*; #(
   parameter int MAX_CHUNKS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  req_type              req_payload,
   input  logic                 rsp_valid,
   input  rsp_type              rsp_payload,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   input  logic [DATA_BITS-1:0] prdata,
   input  logic                 pready,
   output int                   errors,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   logic [CFG_BITS-1:0] keys_per_leaf;
   logic [CFG_BITS-1:0] children_per_node;
   rsp_type             expected_chunks[$];
   int                  chunks_seen;

   initial begin
      errors  = 0;
      pending = 0;
   end

   function automatic void count_error(input string msg);
      errors++;
      if (errors <= REPORT_LIMIT) begin
         $display("%t %s", $realtime, msg);
      end
   endfunction

   function automatic void queue_chunk(input longint unsigned chunk_at,
                                       input longint unsigned keys,
                                       input logic is_last,
                                       input logic [1:0] code);
      rsp_type c;
      c.chunk_start = INDEX_BITS'(chunk_at);
      c.chunk_count = INDEX_BITS'(keys);
      c.last_chunk  = is_last;
      c.status      = code;
      expected_chunks.insert(expected_chunks.size(), c);
   endfunction

   function automatic void predict_chunks(input req_type r);
      longint unsigned lo, hi, kpl, cpn, leaves, nodes, pos, full, half, cnt;
      lo  = r.begin_index;
      hi  = r.end_index;
      kpl = (keys_per_leaf == '0) ? 64'd1 : 64'(keys_per_leaf);
      cpn = (children_per_node < MIN_CHILDREN) ? 64'(MIN_CHILDREN)
                                                : 64'(children_per_node);
      if (hi <= lo) begin
         queue_chunk(lo, 0, 1'b1, ST_EMPTY);
         return;
      end
      leaves = (hi - lo + kpl - 1) / kpl;
      nodes  = (leaves + cpn - 1) / cpn;
      if (nodes > 64'(MAX_CHUNKS)) begin
         queue_chunk(lo, 0, 1'b1, ST_TOO_MANY);
         return;
      end
      pos  = lo;
      full = cpn * kpl;
      while (nodes > 2) begin
         queue_chunk(pos, full, 1'b0, ST_OK);
         pos    += full;
         leaves -= cpn;
         nodes--;
      end
      // two nodes left: the first takes the larger half of the leaves
      if (nodes == 2) begin
         half = (leaves + 1) / 2;
         cnt  = half * kpl;
         queue_chunk(pos, cnt, 1'b0, ST_OK);
         pos += cnt;
      end
      queue_chunk(pos, hi - pos, 1'b1, ST_OK);
   endfunction

   always @(posedge clock) begin
      rsp_type              want;
      logic [DATA_BITS-1:0] reg_value;
      if (reset) begin
         keys_per_leaf     = RESET_KPL;
         children_per_node = RESET_CPN;
         expected_chunks.delete();
         chunks_seen = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_chunks.size() == 0) begin
               count_error($sformatf("unexpected chunk: start %0d count %0d last %0d status %0d",
                  rsp_payload.chunk_start, rsp_payload.chunk_count,
                  rsp_payload.last_chunk, rsp_payload.status));
            end else begin
               want = expected_chunks.pop_front();
               if (rsp_payload.chunk_start !== want.chunk_start ||
                   rsp_payload.chunk_count !== want.chunk_count ||
                   rsp_payload.last_chunk  !== want.last_chunk  ||
                   rsp_payload.status      !== want.status) begin
                  count_error($sformatf({"chunk %0d: expected start %0d count %0d last %0d",
                     " status %0d, got start %0d count %0d last %0d status %0d"},
                     chunks_seen, want.chunk_start, want.chunk_count, want.last_chunk,
                     want.status, rsp_payload.chunk_start, rsp_payload.chunk_count,
                     rsp_payload.last_chunk, rsp_payload.status));
               end
            end
            chunks_seen++;
         end
         if (start && !busy) begin
            predict_chunks(req_payload);
         end
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[ADDR_BITS-1:2] == REG_KPL) begin
                  keys_per_leaf = pwdata[CFG_BITS-1:0];
               end else if (paddr[ADDR_BITS-1:2] == REG_CPN) begin
                  children_per_node = pwdata[CFG_BITS-1:0];
               end
            end else begin
               reg_value = (paddr[ADDR_BITS-1:2] == REG_KPL) ? DATA_BITS'(keys_per_leaf)
                                                              : DATA_BITS'(children_per_node);
               if (prdata !== reg_value) begin
                  count_error($sformatf("register read at %0d: expected %0d, got %0d",
                     paddr, reg_value, prdata));
               end
            end
         end
      end
      pending <= expected_chunks.size();
   end

endmodule

// ===== test/btree_leaf_chunk_splitter_tb.sv =====
// ----------------------------------------------------------------------------
// btree_leaf_chunk_splitter_tb
// Drives key ranges into the chunk splitter under a series of leaf and node
// sizes: the reset sizes, the smallest and largest legal sizes, values that
// the block must clamp, and random sizes. Some settings get boundary ranges,
// and each gets random ranges shaped by the node count they produce, with random gaps
// between requests. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module btree_leaf_chunk_splitter_tb import btlcs_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          HALF_PERIOD   = 2;
   localparam int          RESET_CYCLES  = 9;
   localparam int          MAX_CHUNKS    = 64;
   localparam int          PHASES        = 8;
   localparam int          RANDOM_ITEMS  = 220;
   localparam int          SETTLE_CYCLES = 16;
   localparam int          DRAIN_CYCLES  = 150;
   localparam int unsigned INDEX_MAX     = 32'((64'd1 << INDEX_BITS) - 1);
   localparam logic [DATA_BITS-1:0] CFG_MASK = DATA_BITS'((1 << CFG_BITS) - 1);

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_payload;
   logic                 rsp_valid;
   rsp_type              rsp_payload;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [ADDR_BITS-1:0] paddr;
   logic [DATA_BITS-1:0] pwdata;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;
   int                   errors;
   int                   pending;

   int unsigned kpl_eff;
   int unsigned cpn_eff;
   bit          no_idle;

   btree_leaf_chunk_splitter #(
      .MAX_CHUNKS(MAX_CHUNKS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   btree_leaf_chunk_splitter_checker #(
      .MAX_CHUNKS(MAX_CHUNKS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .errors     (errors),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   function automatic int pick_gap();
      int sel;
      if (no_idle) begin
         return 0;
      end
      sel = $urandom_range(99, 0);
      if (sel < 40) return 0;
      if (sel < 85) return $urandom_range(4, 1);
      if (sel < 97) return $urandom_range(30, 5);
      return $urandom_range(200, 60);
   endfunction

   task automatic csr_access(input logic wr, input logic idx, input logic [DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= ADDR_BITS'({idx, 2'b00});
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_config(input logic [CFG_BITS-1:0] kpl_value,
                             input logic [CFG_BITS-1:0] cpn_value);
      csr_access(1'b1, REG_KPL, ($urandom() & ~CFG_MASK) | DATA_BITS'(kpl_value));
      csr_access(1'b1, REG_CPN, ($urandom() & ~CFG_MASK) | DATA_BITS'(cpn_value));
      csr_access(1'b0, REG_KPL, '0);
      csr_access(1'b0, REG_CPN, '0);
      kpl_eff = (kpl_value == '0) ? 1 : kpl_value;
      cpn_eff = (cpn_value < MIN_CHILDREN) ? MIN_CHILDREN : cpn_value;
   endtask

   task automatic send_range(input int unsigned lo, input int unsigned hi);
      int gap;
      req_payload <= '{begin_index: INDEX_BITS'(lo), end_index: INDEX_BITS'(hi)};
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // a range of random size and place that splits into exactly t nodes
   task automatic send_nodes(input int unsigned t);
      int unsigned leaves, keys, lo;
      leaves = $urandom_range(t * cpn_eff, (t - 1) * cpn_eff + 1);
      keys   = $urandom_range(leaves * kpl_eff, (leaves - 1) * kpl_eff + 1);
      lo     = $urandom_range(INDEX_MAX - keys, 0);
      send_range(lo, lo + keys);
   endtask

   task automatic send_edge_ranges();
      int unsigned full;
      full = kpl_eff * cpn_eff;
      // two nodes with an odd leaf count and, where a leaf holds more than one key, a partial last leaf
      send_range(3, 3 + (2 * cpn_eff - 2) * kpl_eff + 1);
      send_range(INDEX_MAX - MAX_CHUNKS * full, INDEX_MAX);
      send_range(7, 7 + MAX_CHUNKS * full + 1);
   endtask

   task automatic send_random_range();
      int          sel;
      int unsigned lo;
      sel = $urandom_range(99, 0);
      if (sel < 6) begin
         lo = $urandom_range(INDEX_MAX, 0);
         send_range(lo, $urandom_range(lo, 0));
      end else if (sel < 11) begin
         send_range($urandom_range(INDEX_MAX, 0), $urandom_range(INDEX_MAX, 0));
      end else if (sel < 40) begin
         send_nodes($urandom_range(3, 1));
      end else if (sel < 88) begin
         send_nodes($urandom_range(MAX_CHUNKS, 4));
      end else begin
         send_nodes($urandom_range(MAX_CHUNKS + 8, MAX_CHUNKS + 1));
      end
   endtask

   task automatic wait_idle(input int cycles);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      reset       <= 1'b1;
      start       <= 1'b0;
      req_payload <= '0;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      kpl_eff = RESET_KPL;
      cpn_eff = RESET_CPN;
      no_idle = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               csr_access(1'b0, REG_KPL, '0);
               csr_access(1'b0, REG_CPN, '0);
            end
            1: set_config(7'd1, 7'd5);
            2: set_config(7'd64, 7'd64);
            3: set_config(7'd0, 7'd4);
            4: set_config(7'd127, 7'd127);
            5: set_config(7'd2, 7'd0);
            default: set_config(CFG_BITS'($urandom_range(64, 1)),
                                CFG_BITS'($urandom_range(64, 0)));
         endcase
         no_idle = ($urandom_range(3, 0) == 0);

         if (phase == 0) begin
            send_range(0, 0);
            send_range(INDEX_MAX, INDEX_MAX);
            send_range(INDEX_MAX, 0);
            send_range(5, 6);
            send_range(0, 256);
            send_range(0, 257);
            send_range(100, 100 + 3 * 256);
            send_range(0, MAX_CHUNKS * 256);
            send_range(0, MAX_CHUNKS * 256 + 1);
            send_range(0, INDEX_MAX);
            send_range(INDEX_MAX - 1, INDEX_MAX);
            send_range(INDEX_MAX - MAX_CHUNKS * 256, INDEX_MAX);
         end else if (phase == 1 || phase == 2 || phase == 4) begin
            send_edge_ranges();
         end

         for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
            send_random_range();
         end
         wait_idle((phase == PHASES - 1) ? DRAIN_CYCLES : SETTLE_CYCLES);
      end

      if (errors == 0 && pending == 0) begin
         $display("btree_leaf_chunk_splitter_tb: clean");
      end else begin
         $display("btree_leaf_chunk_splitter_tb: errors");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("btree_leaf_chunk_splitter_tb: errors");
      $finish;
   end

endmodule
